>>> rtl/hcbp_pkg.sv
package hcbp_pkg;

    // Table sizing
    localparam int MAX_CODE_LEN = 16;
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Field widths fixed by the interface
    localparam int REQ_W     = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int PBITS_W   = 7;
    localparam int PCOUNT_W  = 3;
    localparam int ACC_W     = PBITS_W + CODE_W;

    // Stored length never exceeds the code word field
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_STORE  = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } req_t;

    // One table entry
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

>>> rtl/huffman_code_bit_packer.sv
// Channel   Handshake             Payload
// -------   -------------------   -------------------------------------------------
// input     in_valid / in_ready   req_type, symbol, code_word, code_length
// output    out_valid / out_ready out_byte, last, missing_code
//
// Two stages: a table read stage, then the packer that merges the code with the
// pending bits. One word is accepted per cycle while each word yields at most one
// byte; a two-byte word holds the packer until its first byte drains, as the
// output port moves one byte per cycle. Reset clears the table valid bits and the
// pending bits at once, no clearing pass. A stalled output backs up into in_ready.
module huffman_code_bit_packer
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hcbp_pkg::REQ_W-1:0]  req_type,
    input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_length,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
    output logic                        last,
    output logic                        missing_code
);
    import hcbp_pkg::*;

    // Code table and its valid bits
    entry_t                  code_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] tbl_valid_reg;

    // Read stage
    logic              s1_valid_reg;
    logic [REQ_W-1:0]  s1_req_reg;
    logic              s1_hit_reg;
    entry_t            s1_entry_reg;

    // Pending bits
    logic [PBITS_W-1:0]  pbits_reg, pbits_next;
    logic [PCOUNT_W-1:0] pcount_reg, pcount_next;

    // Output slot and second-byte slot
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              last_reg, last_next;
    logic              missing_reg, missing_next;
    logic              xtra_valid_reg, xtra_valid_next;
    logic [BYTE_W-1:0] xtra_byte_reg, xtra_byte_next;

    logic                 in_fire;
    logic                 can_load;
    logic                 s2_fire;
    logic                 in_range;
    logic [SYM_IDX_W-1:0] idx;
    logic [LEN_W-1:0]     cap_len;
    entry_t               wr_entry;

    logic [LEN_W-1:0]  clen;
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  rem;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] flush_byte;

    // Handshake
    assign can_load = !xtra_valid_reg && (!out_valid_reg || out_ready);
    assign s2_fire  = s1_valid_reg && can_load;
    assign in_ready = !s1_valid_reg || can_load;
    assign in_fire  = in_valid && in_ready;

    // Address decode and store data
    assign in_range = {1'b0, symbol} < (SYM_W+1)'(SYMBOL_COUNT);
    assign idx      = symbol[SYM_IDX_W-1:0];
    assign cap_len  = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;
    assign wr_entry.len  = cap_len;
    assign wr_entry.code = code_word & CODE_W'(({{CODE_W{1'b0}}, 1'b1} << cap_len) - 1'b1);

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (in_fire && req_type == REQ_STORE && in_range)
        begin
            code_mem[idx] <= wr_entry;
        end
        if (in_fire)
        begin
            s1_entry_reg <= code_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_req_reg    <= '0;
            s1_hit_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire && req_type == REQ_STORE && in_range)
            begin
                tbl_valid_reg[idx] <= 1'b1;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_req_reg   <= req_type;
                s1_hit_reg   <= in_range && tbl_valid_reg[idx];
            end
            else if (s2_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Merge code with pending bits
    assign clen  = s1_hit_reg ? s1_entry_reg.len : '0;
    assign acc   = ({{CODE_W{1'b0}}, pbits_reg} << clen) | {{PBITS_W{1'b0}}, s1_entry_reg.code};
    assign total = {{(LEN_W-PCOUNT_W){1'b0}}, pcount_reg} + clen;
    assign byte0 = BYTE_W'(acc >> (total - LEN_W'(BYTE_W)));
    assign byte1 = BYTE_W'(acc >> (total - LEN_W'(2*BYTE_W)));
    assign rem   = (total >= LEN_W'(2*BYTE_W)) ? total - LEN_W'(2*BYTE_W)
                 : (total >= LEN_W'(BYTE_W))   ? total - LEN_W'(BYTE_W)
                 : total;
    assign flush_byte = BYTE_W'({1'b0, pbits_reg} << (4'd8 - {1'b0, pcount_reg}));

    // Next state of packer and output slots
    always_comb
    begin
        pbits_next      = pbits_reg;
        pcount_next     = pcount_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        missing_next    = missing_reg;
        xtra_valid_next = xtra_valid_reg;
        xtra_byte_next  = xtra_byte_reg;

        // drain current output; second byte moves up
        if (out_valid_reg && out_ready)
        begin
            out_valid_next  = xtra_valid_reg;
            out_byte_next   = xtra_byte_reg;
            last_next       = 1'b1;
            missing_next    = 1'b0;
            xtra_valid_next = 1'b0;
        end

        if (s2_fire)
        begin
            case (s1_req_reg)
                REQ_ENCODE:
                begin
                    if (clen == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        last_next      = 1'b1;
                        missing_next   = 1'b1;
                    end
                    else
                    begin
                        pcount_next = rem[PCOUNT_W-1:0];
                        pbits_next  = acc[PBITS_W-1:0] & ~({PBITS_W{1'b1}} << rem);
                        if (total >= LEN_W'(BYTE_W))
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = byte0;
                            missing_next   = 1'b0;
                            last_next      = (total < LEN_W'(2*BYTE_W));
                        end
                        if (total >= LEN_W'(2*BYTE_W))
                        begin
                            xtra_valid_next = 1'b1;
                            xtra_byte_next  = byte1;
                        end
                    end
                end
                REQ_FLUSH:
                begin
                    if (pcount_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = flush_byte;
                        last_next      = 1'b1;
                        missing_next   = 1'b0;
                        pbits_next     = '0;
                        pcount_next    = '0;
                    end
                end
                default:
                begin
                    // store and unused codes give no byte
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pbits_reg      <= '0;
            pcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
            xtra_valid_reg <= 1'b0;
        end
        else
        begin
            pbits_reg      <= pbits_next;
            pcount_reg     <= pcount_next;
            out_valid_reg  <= out_valid_next;
            xtra_valid_reg <= xtra_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
        missing_reg   <= missing_next;
        xtra_byte_reg <= xtra_byte_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = last_reg;
    assign missing_code = missing_reg;

    // Second byte only queued behind a valid first byte
    a_xtra_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        xtra_valid_reg |-> out_valid_reg)
        else $error("second byte queued without a first byte");

    // Missing code word is a zero byte that ends the word's results
    a_missing_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && missing_reg |-> out_byte_reg == '0 && last_reg)
        else $error("missing code result malformed");

    // Pending bits change only when the packer takes a word
    a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_fire |=> $stable(pcount_reg) && $stable(pbits_reg))
        else $error("pending bits changed without a word");

    // Queued second byte survives an output stall
    a_xtra_hold: assert property (@(posedge clk) disable iff (!rst_n)
        xtra_valid_reg && !out_ready |=> xtra_valid_reg && $stable(xtra_byte_reg))
        else $error("second byte lost during stall");

endmodule
